// ===== rtl/pf_pkg.sv =====
// Shared types, constants and square lookup functions for the Playfair digraph cipher.
// No dependencies; used by the top, pf_pair, pf_encode and the testbench, but not by pf_checker.
package pf_pkg;

	localparam int SIDE = 5;

	localparam logic [4:0] LETTER_X = 5'd23;
	localparam logic [4:0] LETTER_Q = 5'd16;
	localparam logic [4:0] LETTER_Z = 5'd25;

	// configuration register indexes
	localparam logic [2:0] REG_ROW0    = 3'd0;
	localparam logic [2:0] REG_ROW4    = 3'd4;
	localparam logic [2:0] REG_DECRYPT = 3'd5;

	// five 5-bit letter codes, column c at bits 5c+4..5c
	typedef logic [SIDE-1:0][4:0] row_t;
	typedef row_t [SIDE-1:0] square_t;

	localparam square_t SQUARE_RESET = {
		25'd25942708, 25'd20530703, 25'd15118698, 25'd9706693, 25'd4294688
	};

	typedef struct packed {
		logic [4:0] first;
		logic [4:0] second;
	} pair_t;

	typedef struct packed {
		logic [4:0] first_cipher;
		logic [4:0] second_cipher;
		logic       not_found;
	} result_t;

	typedef struct packed {
		logic       found;
		logic [2:0] row;
		logic [2:0] col;
	} loc_t;

	// last match in row-major order wins
	function automatic loc_t locate(square_t sq, logic [4:0] ch);
		loc_t loc;
		loc = '0;
		for (int r = 0; r < SIDE; r++) begin
			for (int c = 0; c < SIDE; c++) begin
				if (sq[r][c] == ch) begin
					loc.found = 1'b1;
					loc.row   = 3'(r);
					loc.col   = 3'(c);
				end
			end
		end
		return loc;
	endfunction

	// one step around the square, wrapping at the edge
	function automatic logic [2:0] wrap_step(logic [2:0] idx, logic dec);
		logic [2:0] nxt;
		if (dec) begin
			nxt = (idx == 3'd0) ? 3'(SIDE - 1) : idx - 3'd1;
		end else begin
			nxt = (idx == 3'(SIDE - 1)) ? 3'd0 : idx + 3'd1;
		end
		return nxt;
	endfunction

endpackage

// ===== rtl/playfair_digraph_cipher_top.sv =====
// Top level of the Playfair digraph cipher: config registers, pair stage, encoder, output register.
// Depends on pf_pkg, pf_pair and pf_encode.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid, in_ready, letter, is_last            | to block
//   out     | out_valid, out_ready, first_cipher,            | from block
//           |   second_cipher, not_found                     |
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data      | to block
//
// One letter is accepted per cycle unless the pair stage is full and the output is stalled; the
// second letter beat loads the pair register, and the output register takes the pair from it
// when it is free to load; the square lookup sits between these two registers.
// Reset loads the default square (A..Y row-major), encrypt mode, and empties the letter hold.
// A stalled output holds its beat; the pair stage still fills with one more pair behind it.
// cfg_ready is always high; writes take effect at once and must come while the block is idle.
module playfair_digraph_cipher_top import pf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [4:0]  letter,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  first_cipher,
	output logic [4:0]  second_cipher,
	output logic        not_found,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [24:0] cfg_data
);

	square_t sq_q;
	logic    decrypt_q;
	logic    take;
	logic    valid_s1;
	pair_t   pair_s1;
	result_t res;
	result_t res_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q      <= SQUARE_RESET;
			decrypt_q <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index <= REG_ROW4) begin
				sq_q[cfg_index] <= cfg_data;
			end else if (cfg_index == REG_DECRYPT) begin
				decrypt_q <= cfg_data[0];
			end
		end
	end

	assign take = !out_valid || out_ready;

	pf_pair u_pair (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.letter   (letter),
		.is_last  (is_last),
		.take     (take),
		.valid_s1 (valid_s1),
		.pair_s1  (pair_s1)
	);

	pf_encode u_encode (
		.sq      (sq_q),
		.decrypt (decrypt_q),
		.pair    (pair_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (take) begin
			out_valid <= valid_s1;
		end
	end

	// hold the beat while stalled
	always_ff @(posedge clk) begin
		if (take && valid_s1) begin
			res_q <= res;
		end
	end

	assign first_cipher  = res_q.first_cipher;
	assign second_cipher = res_q.second_cipher;
	assign not_found     = res_q.not_found;

endmodule

// ===== rtl/pf_pair.sv =====
// Digraph builder: maps Z to Q, holds the first letter, forms pairs into the stage 1 register.
// Depends on pf_pkg.
module pf_pair import pf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [4:0] letter,
	input  logic       is_last,
	input  logic       take,
	output logic       valid_s1,
	output pair_t      pair_s1
);

	logic [4:0] held_q;
	logic       held_valid_q;
	logic [4:0] ch;
	logic       emit;
	pair_t      pair_d;
	logic       accept;

	assign ch       = (letter == LETTER_Z) ? LETTER_Q : letter;
	assign in_ready = !valid_s1 || take;
	assign accept   = in_valid && in_ready;
	assign emit     = held_valid_q || is_last;

	always_comb begin
		if (held_valid_q) begin
			pair_d.first  = held_q;
			// repeated letter: pair with X and drop the incoming one
			pair_d.second = (ch == held_q) ? LETTER_X : ch;
		end else begin
			pair_d.first  = ch;
			pair_d.second = LETTER_X;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '0;
			held_valid_q <= 1'b0;
			valid_s1     <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= accept && emit;
			end
			if (accept) begin
				if (held_valid_q) begin
					held_valid_q <= 1'b0;
				end else if (!is_last) begin
					held_q       <= ch;
					held_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			pair_s1 <= pair_d;
		end
	end

endmodule

// ===== rtl/pf_encode.sv =====
// Square lookup and Playfair substitution for one pair, combinational.
// Depends on pf_pkg.
module pf_encode import pf_pkg::*; (
	input  square_t sq,
	input  logic    decrypt,
	input  pair_t   pair,
	output result_t res
);

	loc_t la;
	loc_t lb;

	assign la = locate(sq, pair.first);
	assign lb = locate(sq, pair.second);

	always_comb begin
		res = '0;
		if (!la.found || !lb.found) begin
			res.not_found = 1'b1;
		end else if (la.row == lb.row) begin
			res.first_cipher  = sq[la.row][wrap_step(la.col, decrypt)];
			res.second_cipher = sq[lb.row][wrap_step(lb.col, decrypt)];
		end else if (la.col == lb.col) begin
			res.first_cipher  = sq[wrap_step(la.row, decrypt)][la.col];
			res.second_cipher = sq[wrap_step(lb.row, decrypt)][lb.col];
		end else begin
			// rectangle: swap columns
			res.first_cipher  = sq[la.row][lb.col];
			res.second_cipher = sq[lb.row][la.col];
		end
	end

endmodule

// ===== rtl/pf_checker.sv =====
// Port-level checks for the Playfair digraph cipher top, attached by bind.
// No package dependency; sees the top-level ports only.
module pf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [4:0] first_cipher,
	input logic [4:0] second_cipher,
	input logic       not_found
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(first_cipher)
			&& $stable(second_cipher) && $stable(not_found))
		else $error("output beat changed while stalled");

	a_nf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && not_found |-> first_cipher == 5'd0 && second_cipher == 5'd0)
		else $error("not_found beat carries nonzero letters");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_rise_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("output beat without an accepted letter");

endmodule

bind playfair_digraph_cipher_top pf_checker u_pf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.first_cipher  (first_cipher),
	.second_cipher (second_cipher),
	.not_found     (not_found)
);

// ===== test/tb.sv =====
// Testbench for playfair_digraph_cipher_top: directed and random letter streams over several
// key squares and both directions, checked against an in-bench digraph predictor.
// Depends on pf_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb;
	import pf_pkg::*;

	localparam int IDLE_PCT     = 34;
	localparam int DRAIN_CYCLES = 6;
	localparam int RANDOM_ITEMS = 1900;
	localparam int RANDOM_PHASES = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [4:0]  letter = '0;
	logic        is_last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [4:0]  first_cipher;
	logic [4:0]  second_cipher;
	logic        not_found;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [24:0] cfg_data = '0;

	// predictor state
	logic [24:0] key_rows [SIDE];
	logic        decrypting;
	logic [4:0]  held_code;
	logic        holding;

	result_t pending_digraphs [$];
	int      fail_count = 0;
	int      random_sent = 0;
	logic    quiet_stretch = 1'b0;

	playfair_digraph_cipher_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.letter(letter),
		.is_last(is_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.first_cipher(first_cipher),
		.second_cipher(second_cipher),
		.not_found(not_found),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= quiet_stretch || ($urandom_range(99) >= IDLE_PCT);
	end

	function automatic logic [4:0] square_cell(int r, int c);
		return key_rows[r % SIDE][5 * (c % SIDE) +: 5];
	endfunction

	// scan all cells; the last hit in row-major order sticks
	function automatic logic find_code(logic [4:0] code, output int row, output int col);
		logic hit;
		hit = 1'b0;
		row = 0;
		col = 0;
		for (int r = 0; r < SIDE; r++) begin
			for (int c = 0; c < SIDE; c++) begin
				if (square_cell(r, c) == code) begin
					hit = 1'b1;
					row = r;
					col = c;
				end
			end
		end
		return hit;
	endfunction

	function automatic result_t cipher_digraph(logic [4:0] a, logic [4:0] b);
		result_t res;
		int ra, ca, rb, cb, shift;
		logic fa, fb;
		res = '0;
		shift = decrypting ? SIDE - 1 : 1;
		fa = find_code(a, ra, ca);
		fb = find_code(b, rb, cb);
		if (!fa || !fb) begin
			res.not_found = 1'b1;
		end else if (ra == rb) begin
			res.first_cipher  = square_cell(ra, ca + shift);
			res.second_cipher = square_cell(rb, cb + shift);
		end else if (ca == cb) begin
			res.first_cipher  = square_cell(ra + shift, ca);
			res.second_cipher = square_cell(rb + shift, cb);
		end else begin
			res.first_cipher  = square_cell(ra, cb);
			res.second_cipher = square_cell(rb, ca);
		end
		return res;
	endfunction

	function automatic void predict_letter(logic [4:0] code, logic last);
		logic [4:0] ch;
		ch = (code == LETTER_Z) ? LETTER_Q : code;
		if (holding) begin
			holding = 1'b0;
			pending_digraphs.push_back(cipher_digraph(held_code, (ch == held_code) ? LETTER_X : ch));
		end else if (last) begin
			pending_digraphs.push_back(cipher_digraph(ch, LETTER_X));
		end else begin
			held_code = ch;
			holding = 1'b1;
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (out_valid && out_ready) begin
			if (pending_digraphs.size() == 0) begin
				$display("%0t: unexpected digraph %0d %0d nf=%0b", $time,
					first_cipher, second_cipher, not_found);
				fail_count++;
			end else begin
				want = pending_digraphs.pop_front();
				if (first_cipher !== want.first_cipher) begin
					$display("%0t: first_cipher expected %0d actual %0d", $time,
						want.first_cipher, first_cipher);
					fail_count++;
				end
				if (second_cipher !== want.second_cipher) begin
					$display("%0t: second_cipher expected %0d actual %0d", $time,
						want.second_cipher, second_cipher);
					fail_count++;
				end
				if (not_found !== want.not_found) begin
					$display("%0t: not_found expected %0b actual %0b", $time,
						want.not_found, not_found);
					fail_count++;
				end
			end
		end
	end

	task automatic send_letter(input logic [4:0] code, input logic last);
		while (!quiet_stretch && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		letter   <= code;
		is_last  <= last;
		do @(posedge clk); while (!in_ready);
		predict_letter(code, last);
	endtask

	// drop valid, then wait out every digraph plus the pipeline tail
	task automatic drain_block();
		in_valid <= 1'b0;
		while (pending_digraphs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_square(input logic [24:0] rows [SIDE], input logic dec);
		for (int i = 0; i <= SIDE; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= (i == SIDE) ? REG_DECRYPT : REG_ROW0 + 3'(i);
			cfg_data  <= (i == SIDE) ? 25'(dec) : rows[i];
			do @(posedge clk); while (!cfg_ready);
			if (i == SIDE) decrypting = dec;
			else key_rows[i] = rows[i];
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic send_list(input logic [4:0] codes [$], input int last_at [$]);
		foreach (codes[i]) send_letter(codes[i], i inside {last_at});
	endtask

	task automatic test_default_encrypt();
		// same row, same column, rectangle, repeats, Z folding, X repeat, odd tail
		send_list('{0, 1, 0, 20, 0, 24, 24, 24, 13, 25, 16, 23, 23, 4, 10, 12, 24},
			'{16});
		// lone last letter, last with a letter held, codes above Z
		send_list('{4, 10, 12, 26, 31, 31, 30, 5, 19}, '{0, 2, 3, 5, 8});
		drain_block();
	endtask

	task automatic test_default_decrypt();
		logic [24:0] rows [SIDE];
		foreach (rows[i]) rows[i] = key_rows[i];
		load_square(rows, 1'b1);
		// wrap left in a row, wrap up in a column, rectangle, repeat
		send_list('{0, 4, 0, 20, 6, 18, 24, 24, 11}, '{8});
		drain_block();
	endtask

	task automatic test_square_extremes();
		logic [24:0] rows [SIDE];
		foreach (rows[i]) rows[i] = '0;
		load_square(rows, 1'b0);
		send_list('{0, 1, 0, 0, 23}, '{4});
		drain_block();
		foreach (rows[i]) rows[i] = '1;
		load_square(rows, 1'b1);
		send_list('{31, 31, 31, 0}, '{2, 3});
		drain_block();
		// reset square with X duplicated in the first cell
		foreach (rows[i]) rows[i] = SQUARE_RESET[i];
		rows[0][4:0] = LETTER_X;
		load_square(rows, 1'b0);
		send_list('{23, 1, 2, 23, 23}, '{4});
		drain_block();
	endtask

	task automatic build_random_square(output logic [24:0] rows [SIDE]);
		logic [4:0] codes [26];
		logic [4:0] tmp;
		int j, kind;
		for (int i = 0; i < 26; i++) codes[i] = 5'(i);
		for (int i = 25; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = codes[i];
			codes[i] = codes[j];
			codes[j] = tmp;
		end
		kind = $urandom_range(9);
		for (int k = 0; k < SIDE * SIDE; k++) begin
			if (kind >= 8) codes[k] = 5'($urandom);
			else if (kind >= 6 && $urandom_range(7) == 0) codes[k] = codes[$urandom_range(24)];
			rows[k / SIDE][5 * (k % SIDE) +: 5] = codes[k];
		end
	endtask

	task automatic send_message(input int len);
		logic [4:0] code, prev;
		prev = '0;
		for (int i = 0; i < len; i++) begin
			if (i > 0 && $urandom_range(9) == 0) code = prev;
			else if ($urandom_range(99) < 3) code = 5'($urandom_range(31, 26));
			else code = 5'($urandom_range(25));
			send_letter(code, i == len - 1);
			prev = code;
			random_sent++;
		end
	endtask

	task automatic test_random_squares();
		logic [24:0] rows [SIDE];
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			build_random_square(rows);
			load_square(rows, 1'(p % 2) ^ 1'($urandom_range(3) == 0));
			quiet_stretch = (p == 3);
			while (random_sent < (p + 1) * RANDOM_ITEMS / RANDOM_PHASES)
				send_message($urandom_range(16, 1));
			drain_block();
			quiet_stretch = 1'b0;
		end
	endtask

	initial begin
		foreach (key_rows[i]) key_rows[i] = SQUARE_RESET[i];
		decrypting = 1'b0;
		held_code  = '0;
		holding    = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_encrypt();
		test_default_decrypt();
		test_square_extremes();
		test_random_squares();
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule
